/* rtl/sorted_set_engine_core_assert.svh */
// Assertion macros for the sorted set engine, used by the sequencer.
`ifndef SORTED_SET_ENGINE_CORE_ASSERT_SVH
`define SORTED_SET_ENGINE_CORE_ASSERT_SVH

// Same-cycle implication, switched off while reset is held.
`define SSE_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sorted set engine: same-cycle check failed");

// Next-cycle implication, switched off while reset is held.
`define SSE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sorted set engine: next-cycle check failed");

`endif

/* rtl/sse_pkg.sv */
// Package of types and constants for the sorted set engine.
package sse_pkg;

    // Default store capacity and field widths.
    localparam int SSE_CAPACITY    = 16;
    localparam int SSE_DATA_W      = 32;
    localparam int SSE_COUNT_OUT_W = 5;

    // Command codes carried by an item.
    typedef enum logic [1:0] {
        CMD_INSERT = 2'd0,
        CMD_DELETE = 2'd1,
        CMD_SEARCH = 2'd2,
        CMD_POP    = 2'd3
    } t_cmd;

    // Status codes returned with every result.
    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_FULL  = 2'd1,
        STAT_EMPTY = 2'd2
    } t_status;

    // Sequencer states.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PROBE,
        ST_COMPARE,
        ST_DECIDE,
        ST_POP_HEAD,
        ST_SHIFT_UP,
        ST_PLACE,
        ST_SHIFT_DN,
        ST_DONE
    } t_state;

    // One result item as handed from the sequencer to the output register.
    typedef struct packed {
        logic                              found;
        logic signed [SSE_DATA_W-1:0]      popped_value;
        logic        [SSE_COUNT_OUT_W-1:0] entry_count;
        t_status                           status;
    } t_result;

endpackage

/* rtl/sorted_set_engine_core.sv */
// Top level of the sorted set engine: sequencer, store RAM and result register.
//
//   channel   direction   handshake                    payload
//   input     in          i_in_valid / o_in_ready      i_cmd, i_value
//   result    out         o_out_valid / i_out_ready    o_found, o_popped_value,
//                                                      o_entry_count, o_status
//
// An item is accepted only once the one before it is done. Insert, delete and search make
// P binary-search probes (at most floor(log2(count)) + 1), each a RAM read and a compare;
// an edit then moves S entries, one per cycle through the single RAM write port, and an
// inserted value is placed after a shift. A pop skips the search, and moves nothing on an
// empty store. Reset empties the store at once through the count.
// The sequencer holds its result while the output register is full; input waits meanwhile.
module sorted_set_engine_core
    import sse_pkg::*;
#(
    parameter int CAPACITY = SSE_CAPACITY
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  logic [1:0]                       i_cmd,
    input  logic signed [SSE_DATA_W-1:0]     i_value,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic                             o_found,
    output logic signed [SSE_DATA_W-1:0]     o_popped_value,
    output logic [SSE_COUNT_OUT_W-1:0]       o_entry_count,
    output logic [1:0]                       o_status
);

    localparam int AW = $clog2(CAPACITY);

    logic                  w_ram_we;
    logic [AW-1:0]         w_ram_waddr;
    logic [SSE_DATA_W-1:0] w_ram_wdata;
    logic [AW-1:0]         w_ram_raddr;
    logic [SSE_DATA_W-1:0] w_ram_rdata;
    logic                  w_res_valid;
    logic                  w_res_take;
    t_result               w_res;

    logic                  r_out_valid;
    t_result               r_out;

    // The result register can load when empty or being emptied.
    assign w_res_take = !r_out_valid || i_out_ready;

    sse_ctrl #(
        .CAPACITY (CAPACITY)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_cmd       (i_cmd),
        .i_value     (i_value),
        .o_res_valid (w_res_valid),
        .i_res_take  (w_res_take),
        .o_res       (w_res),
        .o_ram_we    (w_ram_we),
        .o_ram_waddr (w_ram_waddr),
        .o_ram_wdata (w_ram_wdata),
        .o_ram_raddr (w_ram_raddr),
        .i_ram_rdata (w_ram_rdata)
    );

    sse_ram #(
        .WIDTH (SSE_DATA_W),
        .DEPTH (CAPACITY)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_ram_waddr),
        .i_wdata (w_ram_wdata),
        .i_raddr (w_ram_raddr),
        .o_rdata (w_ram_rdata)
    );

    // Output valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_res_valid) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Output payload.
    always_ff @(posedge i_clk) begin
        if (w_res_valid) begin
            r_out <= w_res;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_found        = r_out.found;
    assign o_popped_value = r_out.popped_value;
    assign o_entry_count  = r_out.entry_count;
    assign o_status       = r_out.status;

endmodule

/* rtl/sse_ram.sv */
// Generic simple dual-port RAM with one write port and a registered read port.
module sse_ram
    import sse_pkg::*;
#(
    parameter int WIDTH = SSE_DATA_W,
    parameter int DEPTH = SSE_CAPACITY
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/sse_ctrl.sv */
// Sequencer: binary search over the stored entries (skipped for a pop), then a shift of the store one entry a cycle.
`include "sorted_set_engine_core_assert.svh"

module sse_ctrl
    import sse_pkg::*;
#(
    parameter int CAPACITY = SSE_CAPACITY
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // Input item channel
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic [1:0]                  i_cmd,
    input  logic signed [SSE_DATA_W-1:0] i_value,
    // Result towards the output register
    output logic                        o_res_valid,
    input  logic                        i_res_take,
    output t_result                     o_res,
    // Store RAM
    output logic                        o_ram_we,
    output logic [$clog2(CAPACITY)-1:0] o_ram_waddr,
    output logic [SSE_DATA_W-1:0]       o_ram_wdata,
    output logic [$clog2(CAPACITY)-1:0] o_ram_raddr,
    input  logic [SSE_DATA_W-1:0]       i_ram_rdata
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    t_state                      r_state, n_state;
    t_cmd                        r_cmd, n_cmd;
    logic signed [SSE_DATA_W-1:0] r_value, n_value;
    logic [CW-1:0]               r_count, n_count;
    logic [CW-1:0]               r_lo, n_lo;
    logic [CW-1:0]               r_hi, n_hi;
    logic [AW-1:0]               r_mid, n_mid;
    logic [AW-1:0]               r_ptr, n_ptr;
    logic                        r_found, n_found;
    logic [SSE_DATA_W-1:0]       r_popped, n_popped;
    t_status                     r_status, n_status;

    logic [CW:0]                 w_sum;
    logic [CW:0]                 w_mid_full;
    logic [AW-1:0]               w_mid;
    logic [CW-1:0]               w_cnt_m1;
    logic [AW-1:0]               w_cnt_m1_addr;
    logic [AW-1:0]               w_lo_addr;
    logic [CW-1:0]               w_ptr_ext;
    logic [31:0]                 w_cnt32;

    // Midpoint of the search window and other derived indexes.
    assign w_sum         = (CW+1)'(r_lo) + (CW+1)'(r_hi);
    assign w_mid_full    = w_sum >> 1;
    assign w_mid         = w_mid_full[AW-1:0];
    assign w_cnt_m1      = r_count - CW'(1);
    assign w_cnt_m1_addr = w_cnt_m1[AW-1:0];
    assign w_lo_addr     = r_lo[AW-1:0];
    assign w_ptr_ext     = CW'(r_ptr);
    assign w_cnt32       = 32'(r_count);

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
    end

    // Working registers of the item in flight.
    always_ff @(posedge i_clk) begin
        r_cmd    <= n_cmd;
        r_value  <= n_value;
        r_lo     <= n_lo;
        r_hi     <= n_hi;
        r_mid    <= n_mid;
        r_ptr    <= n_ptr;
        r_found  <= n_found;
        r_popped <= n_popped;
        r_status <= n_status;
    end

    // Next state, RAM accesses and working values.
    always_comb begin
        n_state     = r_state;
        n_cmd       = r_cmd;
        n_value     = r_value;
        n_count     = r_count;
        n_lo        = r_lo;
        n_hi        = r_hi;
        n_mid       = r_mid;
        n_ptr       = r_ptr;
        n_found     = r_found;
        n_popped    = r_popped;
        n_status    = r_status;
        o_in_ready  = 1'b0;
        o_res_valid = 1'b0;
        o_ram_we    = 1'b0;
        o_ram_waddr = r_ptr;
        o_ram_wdata = i_ram_rdata;
        o_ram_raddr = r_ptr;

        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    n_cmd    = t_cmd'(i_cmd);
                    n_value  = i_value;
                    n_lo     = '0;
                    n_hi     = r_count;
                    n_found  = 1'b0;
                    n_popped = '0;
                    n_status = STAT_OK;
                    if (t_cmd'(i_cmd) == CMD_POP) begin
                        if (r_count == '0) begin
                            n_status = STAT_EMPTY;
                            n_state  = ST_DONE;
                        end else begin
                            o_ram_raddr = '0;
                            n_state     = ST_POP_HEAD;
                        end
                    end else begin
                        n_state = ST_PROBE;
                    end
                end
            end

            // Issue a read of the midpoint while the window is not empty.
            ST_PROBE: begin
                if (r_lo < r_hi) begin
                    o_ram_raddr = w_mid;
                    n_mid       = w_mid;
                    n_state     = ST_COMPARE;
                end else begin
                    n_state = ST_DECIDE;
                end
            end

            // Narrow the window; an equal entry marks the value as present.
            ST_COMPARE: begin
                if ($signed(i_ram_rdata) < r_value) begin
                    n_lo = CW'(r_mid) + CW'(1);
                end else begin
                    n_hi = CW'(r_mid);
                    if (i_ram_rdata == r_value) begin
                        n_found = 1'b1;
                    end
                end
                n_state = ST_PROBE;
            end

            // The lower bound is in r_lo; choose the edit to make.
            ST_DECIDE: begin
                case (r_cmd)
                    CMD_INSERT: begin
                        if (r_found) begin
                            n_state = ST_DONE;
                        end else if (r_count == CW'(CAPACITY)) begin
                            n_status = STAT_FULL;
                            n_state  = ST_DONE;
                        end else if (r_lo == r_count) begin
                            o_ram_we    = 1'b1;
                            o_ram_waddr = w_lo_addr;
                            o_ram_wdata = r_value;
                            n_count     = r_count + CW'(1);
                            n_state     = ST_DONE;
                        end else begin
                            o_ram_raddr = w_cnt_m1_addr;
                            n_ptr       = w_cnt_m1_addr;
                            n_state     = ST_SHIFT_UP;
                        end
                    end
                    CMD_DELETE: begin
                        if (!r_found) begin
                            n_state = ST_DONE;
                        end else if (r_lo == w_cnt_m1) begin
                            n_count = w_cnt_m1;
                            n_state = ST_DONE;
                        end else begin
                            o_ram_raddr = w_lo_addr + AW'(1);
                            n_ptr       = w_lo_addr + AW'(1);
                            n_state     = ST_SHIFT_DN;
                        end
                    end
                    default: begin
                        n_state = ST_DONE;
                    end
                endcase
            end

            // Head entry arrives; close the gap it leaves.
            ST_POP_HEAD: begin
                n_popped = i_ram_rdata;
                if (r_count == CW'(1)) begin
                    n_count = w_cnt_m1;
                    n_state = ST_DONE;
                end else begin
                    o_ram_raddr = AW'(1);
                    n_ptr       = AW'(1);
                    n_state     = ST_SHIFT_DN;
                end
            end

            // Move entries up by one, from the top down to the insert position.
            ST_SHIFT_UP: begin
                o_ram_we    = 1'b1;
                o_ram_waddr = r_ptr + AW'(1);
                o_ram_wdata = i_ram_rdata;
                if (w_ptr_ext == r_lo) begin
                    n_state = ST_PLACE;
                end else begin
                    o_ram_raddr = r_ptr - AW'(1);
                    n_ptr       = r_ptr - AW'(1);
                end
            end

            // Write the new value into the freed slot.
            ST_PLACE: begin
                o_ram_we    = 1'b1;
                o_ram_waddr = w_lo_addr;
                o_ram_wdata = r_value;
                n_count     = r_count + CW'(1);
                n_state     = ST_DONE;
            end

            // Move entries down by one, up to the last stored entry.
            ST_SHIFT_DN: begin
                o_ram_we    = 1'b1;
                o_ram_waddr = r_ptr - AW'(1);
                o_ram_wdata = i_ram_rdata;
                if (w_ptr_ext == w_cnt_m1) begin
                    n_count = w_cnt_m1;
                    n_state = ST_DONE;
                end else begin
                    o_ram_raddr = r_ptr + AW'(1);
                    n_ptr       = r_ptr + AW'(1);
                end
            end

            // Hand the result over once the output register can take it.
            ST_DONE: begin
                if (i_res_take) begin
                    o_res_valid = 1'b1;
                    n_state     = ST_IDLE;
                end
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Result fields.
    assign o_res.found        = r_found;
    assign o_res.popped_value = $signed(r_popped);
    assign o_res.entry_count  = w_cnt32[SSE_COUNT_OUT_W-1:0];
    assign o_res.status       = r_status;

    // The count never passes the capacity.
    `SSE_ASSERT_IMPLY(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= CW'(CAPACITY))
    // A full status is only given when the store really is full.
    `SSE_ASSERT_IMPLY(a_full_real, i_clk, i_rst_n, o_res_valid && r_status == STAT_FULL,
        r_count == CW'(CAPACITY))
    // Only a pop returns a value.
    `SSE_ASSERT_IMPLY(a_pop_only, i_clk, i_rst_n, o_res_valid && r_popped != '0,
        r_cmd == CMD_POP)
    // The downward shift never reaches below the removed position.
    `SSE_ASSERT_IMPLY(a_shift_dn_range, i_clk, i_rst_n, r_state == ST_SHIFT_DN,
        w_ptr_ext > r_lo && w_ptr_ext < r_count)
    // Placing a new value grows the count by exactly one.
    `SSE_ASSERT_NEXT(a_place_grows, i_clk, i_rst_n, r_state == ST_PLACE,
        r_count == $past(r_count) + CW'(1))

endmodule

/* tb/sv/tb_sorted_set_engine_core.sv */
// Self-checking testbench for the sorted set engine: directed and random commands.
`timescale 1ns / 100ps

// Shadow copy of the ordered set, with the queue of replies still owed by the block.
class sorted_set_tracker;
    logic signed [sse_pkg::SSE_DATA_W-1:0] members[$];
    sse_pkg::t_result                      replies_due[$];
    int unsigned                           mismatches;

    function new();
        mismatches = 0;
    endfunction

    function int unsigned pending();
        return replies_due.size();
    endfunction

    // Applies one accepted command to the shadow set and queues the reply it causes.
    function void note_command(sse_pkg::t_cmd cmd, logic signed [sse_pkg::SSE_DATA_W-1:0] value);
        sse_pkg::t_result reply;
        int unsigned      pos;
        int unsigned      held;
        bit               present;
        reply        = '0;
        reply.status = sse_pkg::STAT_OK;
        pos          = 0;
        while (pos < members.size() && members[pos] < value)
            pos++;
        present = (pos < members.size()) && (members[pos] == value);
        case (cmd)
            sse_pkg::CMD_INSERT: begin
                if (present)
                    reply.found = 1'b1;
                else if (members.size() >= sse_pkg::SSE_CAPACITY)
                    reply.status = sse_pkg::STAT_FULL;
                else
                    members.insert(pos, value);
            end
            sse_pkg::CMD_DELETE: begin
                if (present) begin
                    reply.found = 1'b1;
                    members.delete(pos);
                end
            end
            sse_pkg::CMD_SEARCH: begin
                reply.found = present;
            end
            default: begin
                // The value field plays no part in a pop.
                if (members.size() == 0)
                    reply.status = sse_pkg::STAT_EMPTY;
                else
                    reply.popped_value = members.pop_front();
            end
        endcase
        held              = members.size();
        reply.entry_count = held[sse_pkg::SSE_COUNT_OUT_W-1:0];
        replies_due.push_back(reply);
    endfunction

    // Compares one result item with the oldest reply owed.
    function void check_reply(logic found, logic signed [sse_pkg::SSE_DATA_W-1:0] popped,
                              logic [sse_pkg::SSE_COUNT_OUT_W-1:0] count, logic [1:0] status);
        sse_pkg::t_result want;
        if (replies_due.size() == 0) begin
            $display("%0t: result with no command outstanding: found %0b popped %0d",
                     $time, found, popped);
            $display("%0t: count %0d status %0d", $time, count, status);
            mismatches++;
            return;
        end
        want = replies_due.pop_front();
        if (found !== want.found) begin
            $display("%0t: found expected %0b actual %0b", $time, want.found, found);
            mismatches++;
        end
        if (popped !== want.popped_value) begin
            $display("%0t: popped value expected %0d actual %0d", $time, want.popped_value, popped);
            mismatches++;
        end
        if (count !== want.entry_count) begin
            $display("%0t: entry count expected %0d actual %0d", $time, want.entry_count, count);
            mismatches++;
        end
        if (status !== 2'(want.status)) begin
            $display("%0t: status expected %0d actual %0d", $time, want.status, status);
            mismatches++;
        end
    endfunction
endclass

module tb_sorted_set_engine_core;
    import sse_pkg::*;

    localparam int unsigned RANDOM_ITEMS = 1800;
    localparam int unsigned HOLD_CYCLES  = 300;
    localparam int unsigned IDLE_LIMIT   = 3000;
    localparam int unsigned TAIL_CYCLES  = 64;

    logic                         i_clk          = 1'b0;
    logic                         i_rst_n        = 1'b0;
    logic                         i_in_valid     = 1'b0;
    logic                         o_in_ready;
    logic [1:0]                   i_cmd          = 2'(CMD_SEARCH);
    logic signed [SSE_DATA_W-1:0] i_value        = '0;
    logic                         o_out_valid;
    logic                         i_out_ready    = 1'b0;
    logic                         o_found;
    logic signed [SSE_DATA_W-1:0] o_popped_value;
    logic [SSE_COUNT_OUT_W-1:0]   o_entry_count;
    logic [1:0]                   o_status;

    sorted_set_tracker tracker = new();

    // Flags shared between the sender and the receiver, and the watchdog's idle counter.
    bit          calm_stretch = 1'b0;
    bit          hold_request = 1'b0;
    int unsigned idle_cycles  = 0;

    // Keys on the edges of the signed range and around zero, for frequent collisions.
    logic signed [SSE_DATA_W-1:0] edge_keys [8] = '{
        32'sh8000_0000, 32'sh7fff_ffff, 32'sh0000_0000, 32'shffff_ffff,
        32'sh0000_0001, 32'shffff_fffe, 32'sh7fff_fffe, 32'sh8000_0001
    };

    sorted_set_engine_core u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_cmd          (i_cmd),
        .i_value        (i_value),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_found        (o_found),
        .o_popped_value (o_popped_value),
        .o_entry_count  (o_entry_count),
        .o_status       (o_status)
    );

    always #1 i_clk = ~i_clk;

    // Check every result item as it leaves the block.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready)
            tracker.check_reply(o_found, o_popped_value, o_entry_count, o_status);
    end

    // Watchdog on cycles in which neither channel moves an item.
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("[sorted_set_engine_core] ERROR");
            $finish;
        end
    end

    // Receiver: random back-pressure, one long hold-off on request, none in calm stretches.
    initial begin : receiver
        int unsigned stall_left;
        int unsigned roll;
        bit          hold_taken;
        stall_left = 0;
        hold_taken = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_request && !hold_taken) begin
                hold_taken = 1'b1;
                stall_left = HOLD_CYCLES;
            end else if (stall_left == 0 && !calm_stretch) begin
                roll = $urandom_range(0, 99);
                if (roll >= 95)
                    stall_left = $urandom_range(10, 40);
                else if (roll >= 65)
                    stall_left = $urandom_range(1, 3);
            end
            if (stall_left > 0) begin
                i_out_ready <= 1'b0;
                stall_left--;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    // Length of the pause after an item: mostly none or short, now and then long.
    function automatic int unsigned idle_gap();
        int unsigned roll;
        if (calm_stretch)
            return 0;
        roll = $urandom_range(0, 99);
        if (roll < 60)
            return 0;
        if (roll < 93)
            return $urandom_range(1, 3);
        return $urandom_range(15, 60);
    endfunction

    // Offers one item, waits for it to be taken and records it.
    task automatic send_item(input t_cmd cmd, input logic signed [SSE_DATA_W-1:0] value);
        int unsigned gap;
        i_in_valid <= 1'b1;
        i_cmd      <= cmd;
        i_value    <= value;
        do
            @(posedge i_clk);
        while (!o_in_ready);
        tracker.note_command(cmd, value);
        gap = idle_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Command mix leaning towards insertion by the given percentage.
    function automatic t_cmd pick_cmd(int unsigned insert_pct);
        if ($urandom_range(0, 99) < insert_pct)
            return CMD_INSERT;
        case ($urandom_range(0, 2))
            0:       return CMD_DELETE;
            1:       return CMD_SEARCH;
            default: return CMD_POP;
        endcase
    endfunction

    // Key choice: often one already held, so hits are common; otherwise edges or anything.
    function automatic logic signed [SSE_DATA_W-1:0] pick_key();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 35 && tracker.members.size() > 0)
            return tracker.members[$urandom_range(0, tracker.members.size() - 1)];
        if (roll < 55)
            return edge_keys[$urandom_range(0, 7)];
        if (roll < 75)
            return $signed(32'($urandom_range(0, 30))) - 32'sd15;
        return $urandom;
    endfunction

    // Stimulus: reset, directed cases, then random traffic.
    initial begin : sender
        int unsigned insert_pct;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: empty pop, edge keys, duplicate, hits and misses, then fill to capacity.
        send_item(CMD_POP,    32'sd0);
        send_item(CMD_INSERT, 32'sh8000_0000);
        send_item(CMD_INSERT, 32'sh7fff_ffff);
        send_item(CMD_INSERT, 32'sd0);
        send_item(CMD_INSERT, 32'shffff_ffff);
        send_item(CMD_INSERT, 32'sh7fff_ffff);
        send_item(CMD_SEARCH, 32'sh8000_0000);
        send_item(CMD_SEARCH, 32'sd5);
        send_item(CMD_DELETE, 32'sd5);
        send_item(CMD_DELETE, 32'sd0);
        send_item(CMD_POP,    32'sh1234_5678);
        for (int k = 0; k < 14; k++)
            send_item(CMD_INSERT, k * 32'sd1000003 - 32'sd7000000);
        send_item(CMD_INSERT, 32'sd12345);
        send_item(CMD_SEARCH, 32'sh7fff_ffff);

        // Random: the insert bias changes every block of items so the store fills and drains.
        insert_pct = 50;
        for (int unsigned n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % 150 == 0) begin
                case ($urandom_range(0, 2))
                    0:       insert_pct = 80;
                    1:       insert_pct = 50;
                    default: insert_pct = 20;
                endcase
            end
            if (n == 400)
                hold_request = 1'b1;
            if (n == 900) begin
                // Let every result drain before going on.
                i_in_valid <= 1'b0;
                while (tracker.pending() != 0)
                    @(posedge i_clk);
            end
            calm_stretch = (n >= 1200 && n < 1400);
            send_item(pick_cmd(insert_pct), pick_key());
        end

        // Drain and let any stray result show itself.
        i_in_valid <= 1'b0;
        while (tracker.pending() != 0)
            @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (tracker.mismatches == 0 && tracker.pending() == 0)
            $display("[sorted_set_engine_core] OK");
        else
            $display("[sorted_set_engine_core] ERROR");
        $finish;
    end

endmodule
